@@ rtl/grid_word_search_macros.svh @@
// Assertion macros shared by the grid word search RTL.
// Each macro expects i_clk and i_rst_n in scope, and checks nothing while reset is low.
`ifndef GRID_WORD_SEARCH_MACROS_SVH
`define GRID_WORD_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gws_pkg.sv @@
`default_nettype none

package gws_pkg;

    // Storage sizes.
    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int MAX_WORD = 16;

    // Fixed field widths of the request and result ports.
    localparam int MODE_W = 2;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int CHAR_W = 8;
    localparam int WIDX_W = 4;
    localparam int LEN_W  = 5;
    localparam int CFG_W  = 6;
    localparam int DIR_W  = 2;

    // Derived widths.
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
    localparam int KW     = $clog2(MAX_WORD);
    localparam int POS_W  = $clog2(MAX_ROWS + MAX_COLS + MAX_WORD) + 1;

    // Request queue between the front and the engine.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;
    localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 6'd32;
    localparam logic [CFG_W-1:0] GRID_COLS_RESET = 6'd32;

    // Request mode codes on the input port.
    localparam logic [MODE_W-1:0] MODE_CELL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WORD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    typedef enum logic [1:0] {
        OP_CELL,
        OP_WORD,
        OP_SEARCH
    } t_op;

    typedef enum logic [DIR_W-1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_DOWN_RIGHT,
        DIR_DOWN_LEFT
    } t_dir;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_EMIT,
        S_MISS
    } t_state;

    // One classified request as it travels through the queue.
    typedef struct packed {
        t_op               op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] chr;
        logic [WIDX_W-1:0] widx;
        logic [LEN_W-1:0]  len;
    } t_req;

    // Queue status seen by the engine.
    typedef struct packed {
        logic empty;
        t_req head;
    } t_q_out;

    // Live grid size.
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } t_cfg;

    // Row step of each direction.
    function automatic logic signed [1:0] dir_dr(input t_dir d);
        logic signed [1:0] s;
        unique case (d)
            DIR_RIGHT: s = 2'sd0;
            default:   s = 2'sd1;
        endcase
        return s;
    endfunction

    // Column step of each direction.
    function automatic logic signed [1:0] dir_dc(input t_dir d);
        logic signed [1:0] s;
        unique case (d)
            DIR_DOWN:      s = 2'sd0;
            DIR_DOWN_LEFT: s = -2'sd1;
            default:       s = 2'sd1;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/grid_word_search.sv @@
`default_nettype none

// Channel    Direction  Handshake              Payload
// request    in         i_start, o_busy        i_mode, i_cell_row, i_cell_col, i_char_value,
//                                              i_word_index, i_word_length
// result     out        o_valid (one cycle)    o_found, o_match_row, o_match_col,
//                                              o_match_char, o_direction, o_last
// config     in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// A request is taken when i_start is high and o_busy is low; o_busy is high only while the
// two-entry queue is full behind a search that holds the engine.
// Grid and word loads are written as they leave the queue; loads stream at one per cycle
// while no search holds the engine. A search leaves the queue, then, for each start cell in
// four directions, reads each character from the grid (registered, S_CHECK), compares it
// in S_CMP, and drops an off-grid probe in S_CHECK; then emits each result, or a not-found.
// Reset clears control state only; the grid and word buffer hold garbage until loaded.
// Results are shown for one cycle each; the receiver cannot stall them.

module grid_word_search import gws_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [ROW_W-1:0]     i_cell_row,
    input  wire logic [COL_W-1:0]     i_cell_col,
    input  wire logic [CHAR_W-1:0]    i_char_value,
    input  wire logic [WIDX_W-1:0]    i_word_index,
    input  wire logic [LEN_W-1:0]     i_word_length,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_valid,
    output logic                      o_found,
    output logic [ROW_W-1:0]          o_match_row,
    output logic [COL_W-1:0]          o_match_col,
    output logic [CHAR_W-1:0]         o_match_char,
    output logic [DIR_W-1:0]          o_direction,
    output logic                      o_last
);

    logic [CFG_W-1:0] r_grid_rows;
    logic [CFG_W-1:0] r_grid_cols;
    t_cfg             cfg;
    t_req             req;
    t_q_out           q_out;
    logic             push;
    logic             pop;
    logic             full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_ROWS_RESET;
            r_grid_cols <= GRID_COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
            endcase
        end
    end

    assign cfg.rows = r_grid_rows;
    assign cfg.cols = r_grid_cols;
    assign o_busy   = full;

    // Request intake and classification.
    gws_front u_front (
        .i_start       (i_start),
        .i_full        (full),
        .i_mode        (i_mode),
        .i_cell_row    (i_cell_row),
        .i_cell_col    (i_cell_col),
        .i_char_value  (i_char_value),
        .i_word_index  (i_word_index),
        .i_word_length (i_word_length),
        .o_req         (req),
        .o_push        (push)
    );

    // Queue between intake and engine.
    gws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_q     (q_out),
        .o_full  (full)
    );

    // Load and search engine.
    gws_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_q          (q_out),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_match_row  (o_match_row),
        .o_match_col  (o_match_col),
        .o_match_char (o_match_char),
        .o_direction  (o_direction),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/gws_front.sv @@
`default_nettype none

module gws_front import gws_pkg::*; (
    input  wire logic              i_start,
    input  wire logic              i_full,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [ROW_W-1:0]  i_cell_row,
    input  wire logic [COL_W-1:0]  i_cell_col,
    input  wire logic [CHAR_W-1:0] i_char_value,
    input  wire logic [WIDX_W-1:0] i_word_index,
    input  wire logic [LEN_W-1:0]  i_word_length,
    output t_req                   o_req,
    output logic                   o_push
);

    logic accept;
    logic useful;
    t_op  op;

    // A request is taken whenever the queue has room.
    assign accept = i_start && !i_full;

    // Classify the mode; the unused mode is taken and dropped here.
    always_comb begin
        useful = 1'b1;
        op     = OP_CELL;
        unique case (i_mode)
            MODE_CELL:   op = OP_CELL;
            MODE_WORD:   op = OP_WORD;
            MODE_SEARCH: op = OP_SEARCH;
            MODE_NONE:   useful = 1'b0;
        endcase
    end

    assign o_push = accept && useful;

    always_comb begin
        o_req.op   = op;
        o_req.row  = i_cell_row;
        o_req.col  = i_cell_col;
        o_req.chr  = i_char_value;
        o_req.widx = i_word_index;
        o_req.len  = i_word_length;
    end

endmodule

`default_nettype wire

@@ rtl/gws_queue.sv @@
`default_nettype none
`include "grid_word_search_macros.svh"

module gws_queue import gws_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    input  wire logic i_pop,
    output t_q_out    o_q,
    output logic      o_full
);

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wp;
    logic [QPTR_W-1:0] n_rp;
    logic [QCNT_W-1:0] n_count;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_q.empty    = (r_count == '0);
    assign o_q.head     = r_mem[r_rp];

    // Pointer and fill count updates.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    `GWS_ASSERT_SAME(a_no_push_full, i_push, !o_full, "request pushed into a full queue")
    `GWS_ASSERT_SAME(a_no_pop_empty, i_pop, !o_q.empty, "request popped from an empty queue")
    `GWS_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + QCNT_W'(1), "queue count did not rise")

endmodule

`default_nettype wire

@@ rtl/gws_engine.sv @@
`default_nettype none
`include "grid_word_search_macros.svh"

module gws_engine import gws_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_q_out             i_q,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [ROW_W-1:0]        o_match_row,
    output logic [COL_W-1:0]        o_match_col,
    output logic [CHAR_W-1:0]       o_match_char,
    output logic [DIR_W-1:0]        o_direction,
    output logic                    o_last
);

    // Storage.
    logic [CHAR_W-1:0] r_grid [MAX_ROWS * MAX_COLS];
    logic [CHAR_W-1:0] r_word [MAX_WORD];
    logic [CHAR_W-1:0] r_rd_data;

    // Control and scan state.
    t_state                   r_state;
    t_state                   n_state;
    t_dir                     r_dir;
    t_dir                     n_dir;
    logic [ROW_W-1:0]         r_sr;
    logic [ROW_W-1:0]         n_sr;
    logic [COL_W-1:0]         r_sc;
    logic [COL_W-1:0]         n_sc;
    logic signed [POS_W-1:0]  r_cr;
    logic signed [POS_W-1:0]  n_cr;
    logic signed [POS_W-1:0]  r_cc;
    logic signed [POS_W-1:0]  n_cc;
    logic [KW-1:0]            r_k;
    logic [KW-1:0]            n_k;
    logic [KW-1:0]            r_lenm1;
    logic [KW-1:0]            n_lenm1;
    logic [CFG_W-1:0]         r_rows;
    logic [CFG_W-1:0]         n_rows;
    logic [CFG_W-1:0]         r_cols;
    logic [CFG_W-1:0]         n_cols;

    // Result registers.
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic                     r_out_found;
    logic                     n_out_found;
    logic [ROW_W-1:0]         r_out_row;
    logic [ROW_W-1:0]         n_out_row;
    logic [COL_W-1:0]         r_out_col;
    logic [COL_W-1:0]         n_out_col;
    logic [CHAR_W-1:0]        r_out_char;
    logic [CHAR_W-1:0]        n_out_char;
    t_dir                     r_out_dir;
    t_dir                     n_out_dir;
    logic                     r_out_last;
    logic                     n_out_last;

    // Decode and helper signals.
    logic                     is_search;
    logic                     len_ok;
    logic [CFG_W-1:0]         sat_rows;
    logic [CFG_W-1:0]         sat_cols;
    logic                     search_ok;
    logic                     in_bounds;
    logic                     hit;
    logic                     k_last;
    logic                     last_c;
    logic                     last_r;
    logic                     scan_end;
    logic [ROW_W-1:0]         adv_sr;
    logic [COL_W-1:0]         adv_sc;
    t_dir                     adv_dir;
    logic signed [POS_W-1:0]  step_r;
    logic signed [POS_W-1:0]  step_c;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     grid_we;
    logic                     word_we;

    assign o_pop     = (r_state == S_IDLE) && !i_q.empty;
    assign is_search = o_pop && (i_q.head.op == OP_SEARCH);
    assign len_ok    = (i_q.head.len != '0) && (32'(i_q.head.len) <= MAX_WORD);
    assign sat_rows  = (32'(i_cfg.rows) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : i_cfg.rows;
    assign sat_cols  = (32'(i_cfg.cols) > MAX_COLS) ? CFG_W'(MAX_COLS) : i_cfg.cols;
    assign search_ok = len_ok && (sat_rows != '0) && (sat_cols != '0);

    // Loads are carried out in the cycle they leave the queue.
    assign grid_we = o_pop && (i_q.head.op == OP_CELL)
                     && (32'(i_q.head.row) < MAX_ROWS) && (32'(i_q.head.col) < MAX_COLS);
    assign word_we = o_pop && (i_q.head.op == OP_WORD) && (32'(i_q.head.widx) < MAX_WORD);
    assign wr_addr = ADDR_W'(i_q.head.row) * ADDR_W'(MAX_COLS) + ADDR_W'(i_q.head.col);

    // Current probe position against the live grid size.
    assign in_bounds = (r_cr >= 0) && (r_cr < $signed(POS_W'(r_rows)))
                       && (r_cc >= 0) && (r_cc < $signed(POS_W'(r_cols)));
    assign rd_addr   = ADDR_W'(r_cr[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                       + ADDR_W'(r_cc[COL_W-1:0]);
    assign hit       = (r_rd_data == r_word[r_k]);
    assign k_last    = (r_k == r_lenm1);
    assign step_r    = POS_W'(dir_dr(r_dir));
    assign step_c    = POS_W'(dir_dc(r_dir));

    // Next start cell in direction-major raster order.
    assign last_c   = ((CFG_W'(r_sc) + CFG_W'(1)) == r_cols);
    assign last_r   = ((CFG_W'(r_sr) + CFG_W'(1)) == r_rows);
    assign scan_end = last_c && last_r && (r_dir == DIR_DOWN_LEFT);

    always_comb begin
        adv_sr  = r_sr;
        adv_sc  = r_sc + COL_W'(1);
        adv_dir = r_dir;
        if (last_c) begin
            adv_sc = '0;
            if (last_r) begin
                adv_sr  = '0;
                adv_dir = t_dir'(r_dir + DIR_W'(1));
            end else begin
                adv_sr = r_sr + ROW_W'(1);
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (is_search) begin
                    n_state = search_ok ? S_CHECK : S_MISS;
                end
            end
            S_CHECK: begin
                if (in_bounds) begin
                    n_state = S_CMP;
                end else if (scan_end) begin
                    n_state = S_MISS;
                end
            end
            S_CMP: begin
                if (hit) begin
                    n_state = k_last ? S_EMIT : S_CHECK;
                end else begin
                    n_state = scan_end ? S_MISS : S_CHECK;
                end
            end
            S_EMIT: begin
                if (k_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MISS:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result outputs.
    always_comb begin
        n_dir       = r_dir;
        n_sr        = r_sr;
        n_sc        = r_sc;
        n_cr        = r_cr;
        n_cc        = r_cc;
        n_k         = r_k;
        n_lenm1     = r_lenm1;
        n_rows      = r_rows;
        n_cols      = r_cols;
        n_out_valid = 1'b0;
        n_out_found = r_out_found;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_char  = r_out_char;
        n_out_dir   = r_out_dir;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (is_search) begin
                    n_dir   = DIR_RIGHT;
                    n_sr    = '0;
                    n_sc    = '0;
                    n_cr    = '0;
                    n_cc    = '0;
                    n_k     = '0;
                    n_lenm1 = KW'(i_q.head.len - LEN_W'(1));
                    n_rows  = sat_rows;
                    n_cols  = sat_cols;
                end
            end
            S_CHECK, S_CMP: begin
                if ((r_state == S_CMP) && hit && !k_last) begin
                    // Character matched: move to the next one along the line.
                    n_k  = r_k + KW'(1);
                    n_cr = r_cr + step_r;
                    n_cc = r_cc + step_c;
                end else if ((r_state == S_CMP) && hit) begin
                    // Whole word matched: replay the line from its start.
                    n_k  = '0;
                    n_cr = $signed(POS_W'(r_sr));
                    n_cc = $signed(POS_W'(r_sc));
                end else if ((r_state == S_CMP) || !in_bounds) begin
                    // Candidate failed: move on to the next start cell.
                    n_dir = adv_dir;
                    n_sr  = adv_sr;
                    n_sc  = adv_sc;
                    n_cr  = $signed(POS_W'(adv_sr));
                    n_cc  = $signed(POS_W'(adv_sc));
                    n_k   = '0;
                end
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_out_found = 1'b1;
                n_out_row   = r_cr[ROW_W-1:0];
                n_out_col   = r_cc[COL_W-1:0];
                n_out_char  = r_word[r_k];
                n_out_dir   = r_dir;
                n_out_last  = k_last;
                n_k         = r_k + KW'(1);
                n_cr        = r_cr + step_r;
                n_cc        = r_cc + step_c;
            end
            S_MISS: begin
                n_out_valid = 1'b1;
                n_out_found = 1'b0;
                n_out_row   = '0;
                n_out_col   = '0;
                n_out_char  = '0;
                n_out_dir   = DIR_RIGHT;
                n_out_last  = 1'b1;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_dir      <= n_dir;
        r_sr       <= n_sr;
        r_sc       <= n_sc;
        r_cr       <= n_cr;
        r_cc       <= n_cc;
        r_k        <= n_k;
        r_lenm1    <= n_lenm1;
        r_rows     <= n_rows;
        r_cols     <= n_cols;
        r_out_found <= n_out_found;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_char <= n_out_char;
        r_out_dir  <= n_out_dir;
        r_out_last <= n_out_last;
    end

    // Grid memory: one write port for loads, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            r_grid[wr_addr] <= i_q.head.chr;
        end
        r_rd_data <= r_grid[rd_addr];
    end

    // Word buffer.
    always_ff @(posedge i_clk) begin
        if (word_we) begin
            r_word[KW'(i_q.head.widx)] <= i_q.head.chr;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_match_row  = r_out_row;
    assign o_match_col  = r_out_col;
    assign o_match_char = r_out_char;
    assign o_direction  = DIR_W'(r_out_dir);
    assign o_last       = r_out_last;

    `GWS_ASSERT_NEXT(a_emit_strobes, (r_state == S_EMIT) || (r_state == S_MISS), r_out_valid, "result state gave no strobe")
    `GWS_ASSERT_NEXT(a_quiet_scan, (r_state == S_CHECK) || (r_state == S_CMP), !r_out_valid, "strobe raised while scanning")
    `GWS_ASSERT_SAME(a_miss_is_last, r_out_valid && !r_out_found, r_out_last, "not-found result not marked last")
    `GWS_ASSERT_SAME(a_k_in_word, r_state == S_EMIT, r_k <= r_lenm1, "character count ran past the word")

endmodule

`default_nettype wire

@@ bench/tb_grid_word_search.sv @@
module tb_grid_word_search;
    import gws_pkg::*;

    // The directed section sends about 120 requests; the random phases add the rest.
    localparam int RANDOM_ITEMS = 110;
    localparam int QUIET_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    // A search compares at most 4 directions x cells x 16 characters.
    // The stimulus keeps every grid at 64 cells or fewer, so CYCLE_LIMIT is several times
    // the slowest correct run.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    // One result as it appears on the result ports.
    typedef struct packed {
        logic              found;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] chr;
        logic [DIR_W-1:0]  dir;
        logic              last;
    } hit_t;

    // Mirror of the grid, the word and the grid size, with the results still owed.
    class hit_ledger;
        bit [CHAR_W-1:0] cells [MAX_ROWS*MAX_COLS];
        bit [CHAR_W-1:0] word_chars [MAX_WORD];
        bit [CFG_W-1:0]  rows_reg;
        bit [CFG_W-1:0]  cols_reg;
        hit_t            hits_due [$];
        int              errors;

        function new();
            rows_reg = GRID_ROWS_RESET;
            cols_reg = GRID_COLS_RESET;
            errors   = 0;
        endfunction

        function int row_step(t_dir d);
            return (d == DIR_RIGHT) ? 0 : 1;
        endfunction

        function int col_step(t_dir d);
            return (d == DIR_DOWN) ? 0 : ((d == DIR_DOWN_LEFT) ? -1 : 1);
        endfunction

        function int pending();
            return hits_due.size();
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_GRID_ROWS) begin
                rows_reg = data;
            end else if (idx == CFG_GRID_COLS) begin
                cols_reg = data;
            end
        endfunction

        // True when the word lies at (r0, c0) in direction d without leaving the grid.
        function bit word_at(int r0, int c0, t_dir d, int len, int rows, int cols);
            int r;
            int c;
            for (int k = 0; k < len; k++) begin
                r = r0 + row_step(d) * k;
                c = c0 + col_step(d) * k;
                if (r < 0 || r >= rows || c < 0 || c >= cols) return 1'b0;
                if (cells[r*MAX_COLS + c] != word_chars[k]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Queue the results of a search: the first match by direction, then raster order.
        function void find_first_hit(int len);
            int   rows;
            int   cols;
            t_dir d;
            hit_t h;
            rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
            cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
            if (len >= 1 && len <= MAX_WORD) begin
                for (int di = 0; di < 4; di++) begin
                    d = t_dir'(di);
                    for (int r0 = 0; r0 < rows; r0++) begin
                        for (int c0 = 0; c0 < cols; c0++) begin
                            if (word_at(r0, c0, d, len, rows, cols)) begin
                                for (int k = 0; k < len; k++) begin
                                    h.found = 1'b1;
                                    h.row   = ROW_W'(r0 + row_step(d) * k);
                                    h.col   = COL_W'(c0 + col_step(d) * k);
                                    h.chr   = word_chars[k];
                                    h.dir   = d;
                                    h.last  = (k == len - 1);
                                    hits_due.insert(hits_due.size(), h);
                                end
                                return;
                            end
                        end
                    end
                end
            end
            h      = '0;
            h.last = 1'b1;
            hits_due.insert(hits_due.size(), h);
        endfunction

        // Apply one accepted request to the mirror.
        function void note_request(logic [MODE_W-1:0] mode, logic [ROW_W-1:0] row,
                                   logic [COL_W-1:0] col, logic [CHAR_W-1:0] chr,
                                   logic [WIDX_W-1:0] widx, logic [LEN_W-1:0] len);
            case (mode)
                MODE_CELL: begin
                    cells[row*MAX_COLS + col] = chr;
                end
                MODE_WORD: begin
                    word_chars[widx] = chr;
                end
                MODE_SEARCH: begin
                    find_first_hit(len);
                end
                default: begin
                end
            endcase
        endfunction

        function string show(hit_t h);
            return $sformatf("found=%0d row=%0d col=%0d char=%02h dir=%0d last=%0d",
                             h.found, h.row, h.col, h.chr, h.dir, h.last);
        endfunction

        function void flag(string why, hit_t want, hit_t got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%s: expected %s, got %s", why, show(want), show(got));
            end
        endfunction

        function void check_hit(hit_t got);
            hit_t want;
            if (hits_due.size() == 0) begin
                flag("result with none outstanding", '0, got);
                return;
            end
            want = hits_due.pop_front();
            if (got.found !== want.found || got.row !== want.row || got.col !== want.col ||
                    got.chr !== want.chr || got.dir !== want.dir || got.last !== want.last) begin
                flag("result mismatch", want, got);
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_start       = 1'b0;
    logic [MODE_W-1:0]    i_mode        = MODE_NONE;
    logic [ROW_W-1:0]     i_cell_row    = '0;
    logic [COL_W-1:0]     i_cell_col    = '0;
    logic [CHAR_W-1:0]    i_char_value  = '0;
    logic [WIDX_W-1:0]    i_word_index  = '0;
    logic [LEN_W-1:0]     i_word_length = '0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_GRID_ROWS;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic                 o_found;
    logic [ROW_W-1:0]     o_match_row;
    logic [COL_W-1:0]     o_match_col;
    logic [CHAR_W-1:0]    o_match_char;
    logic [DIR_W-1:0]     o_direction;
    logic                 o_last;

    hit_ledger   ledger = new();
    bit          cell_known [MAX_ROWS*MAX_COLS];
    bit          char_known [MAX_WORD];
    bit          calm = 1'b0;
    int          items_sent = 0;
    int unsigned cycle_count = 0;
    logic [CHAR_W-1:0] alpha_base = 8'h41;
    int          alpha_size = 4;

    grid_word_search u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_mode       (i_mode),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_char_value (i_char_value),
        .i_word_index (i_word_index),
        .i_word_length(i_word_length),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_match_row  (o_match_row),
        .o_match_col  (o_match_col),
        .o_match_char (o_match_char),
        .o_direction  (o_direction),
        .o_last       (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Every strobed result is checked against the oldest outstanding one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            ledger.check_hit({o_found, o_match_row, o_match_col, o_match_char,
                              o_direction, o_last});
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one request, idling each cycle at random first, and wait until it is taken.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col, input logic [CHAR_W-1:0] chr,
                                input logic [WIDX_W-1:0] widx, input logic [LEN_W-1:0] len);
        while (!calm && $urandom_range(99) < 22) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_mode        <= mode;
        i_cell_row    <= row;
        i_cell_col    <= col;
        i_char_value  <= chr;
        i_word_index  <= widx;
        i_word_length <= len;
        i_start       <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        ledger.note_request(mode, row, col, chr, widx, len);
        if (mode == MODE_CELL) cell_known[row*MAX_COLS + col] = 1'b1;
        if (mode == MODE_WORD) char_known[widx] = 1'b1;
        if (mode != MODE_NONE) items_sent++;
    endtask

    task automatic load_cell(input int r, input int c, input logic [CHAR_W-1:0] chr);
        send_request(MODE_CELL, ROW_W'(r), COL_W'(c), chr, WIDX_W'($urandom),
                     LEN_W'($urandom));
    endtask

    task automatic load_char(input int idx, input logic [CHAR_W-1:0] chr);
        send_request(MODE_WORD, ROW_W'($urandom), COL_W'($urandom), chr, WIDX_W'(idx),
                     LEN_W'($urandom));
    endtask

    task automatic search(input int len);
        send_request(MODE_SEARCH, ROW_W'($urandom), COL_W'($urandom), CHAR_W'($urandom),
                     WIDX_W'($urandom), LEN_W'(len));
    endtask

    task automatic noise();
        send_request(MODE_NONE, ROW_W'($urandom), COL_W'($urandom), CHAR_W'($urandom),
                     WIDX_W'($urandom), LEN_W'($urandom));
    endtask

    // Drop start and wait until every result is in and queued loads have drained.
    task automatic wait_quiet();
        i_start <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Write both size registers, in either order, while the block is idle.
    task automatic set_grid(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
        bit cols_first;
        cols_first = $urandom_range(1);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= cols_first ? CFG_GRID_COLS : CFG_GRID_ROWS;
        i_cfg_data <= cols_first ? cols_val : rows_val;
        @(posedge i_clk);
        ledger.note_register(i_cfg_idx, i_cfg_data);
        i_cfg_idx  <= cols_first ? CFG_GRID_ROWS : CFG_GRID_COLS;
        i_cfg_data <= cols_first ? rows_val : cols_val;
        @(posedge i_clk);
        ledger.note_register(i_cfg_idx, i_cfg_data);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly a small alphabet so that words recur; now and then any byte.
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(99) < 10) return CHAR_W'($urandom);
        return alpha_base + CHAR_W'($urandom_range(alpha_size - 1));
    endfunction

    // Load a word, often plant it in the grid, then search for it.
    task automatic search_sequence(input int rows, input int cols, input int lim);
        int   roll;
        int   len;
        int   dr;
        int   dc;
        int   span_r;
        int   span_c;
        int   r0;
        int   c0;
        bit   reuse;
        t_dir d;
        roll = $urandom_range(99);
        if (roll < 4) begin
            len = 0;
        end else if (roll < 8) begin
            len = $urandom_range(MAX_WORD + 1, 31);
        end else begin
            len = $urandom_range(1, lim);
        end
        if (len >= 1 && len <= MAX_WORD) begin
            // Sometimes search again with the word already held.
            reuse = ($urandom_range(99) < 20);
            for (int k = 0; k < len; k++) begin
                if (!char_known[k]) reuse = 1'b0;
            end
            if (!reuse) begin
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 5) noise();
                    load_char(k, pick_char());
                end
            end
            if ($urandom_range(99) < 60) begin
                d      = t_dir'($urandom_range(3));
                dr     = ledger.row_step(d);
                dc     = ledger.col_step(d);
                span_r = dr * (len - 1);
                span_c = ((dc < 0) ? -dc : dc) * (len - 1);
                if (span_r < rows && span_c < cols) begin
                    r0 = $urandom_range(0, rows - 1 - span_r);
                    c0 = (dc < 0) ? $urandom_range(span_c, cols - 1)
                                  : $urandom_range(0, cols - 1 - span_c);
                    for (int k = 0; k < len; k++) begin
                        load_cell(r0 + dr * k, c0 + dc * k, ledger.word_chars[k]);
                    end
                end
            end
        end
        if ($urandom_range(99) < 10) load_cell($urandom_range(31), $urandom_range(31), pick_char());
        search(len);
    endtask

    // One grid size: fill whatever a search could read, then run a few searches.
    task automatic run_phase(input int rows_val, input int cols_val, input int searches,
                             input int max_len);
        int rows;
        int cols;
        int lim;
        bit refresh;
        set_grid(CFG_W'(rows_val), CFG_W'(cols_val));
        rows       = (rows_val > MAX_ROWS) ? MAX_ROWS : rows_val;
        cols       = (cols_val > MAX_COLS) ? MAX_COLS : cols_val;
        alpha_base = CHAR_W'($urandom);
        alpha_size = $urandom_range(2, 4);
        refresh    = ($urandom_range(99) < 70);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (refresh || !cell_known[r*MAX_COLS + c]) load_cell(r, c, pick_char());
            end
        end
        lim = ((rows > cols) ? rows : cols) + 1;
        if (lim > max_len) lim = max_len;
        repeat (searches) search_sequence(rows, cols, lim);
    endtask

    initial begin
        int phase;
        int roll;
        int rv;
        int cv;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bad word lengths and the unused mode read no stored data.
        search(0);
        search(MAX_WORD + 1);
        search(31);
        noise();

        // Empty grid in either dimension.
        set_grid(CFG_W'(0), CFG_W'(63));
        load_char(0, 8'h00);
        search(1);
        set_grid(CFG_W'(63), CFG_W'(0));
        search(1);

        // A single full-height column: a maximum-length word down to the bottom edge.
        set_grid(CFG_W'(63), CFG_W'(1));
        for (int r = 0; r < MAX_ROWS; r++) begin
            load_cell(r, 0, (r == 0) ? 8'h00 : ((r == MAX_ROWS - 1) ? 8'hFF : CHAR_W'(8'h40 + r)));
        end
        for (int k = 0; k < MAX_WORD; k++) load_char(k, ledger.cells[(16 + k)*MAX_COLS]);
        search(MAX_WORD);
        load_char(0, 8'h45);
        search(1);

        // A single full-width row: a word at the right edge, then one that would wrap.
        set_grid(CFG_W'(1), CFG_W'(32));
        for (int c = 0; c < MAX_COLS; c++) load_cell(0, c, CHAR_W'(8'h80 + c));
        for (int k = 0; k < MAX_WORD; k++) load_char(k, CHAR_W'(8'h90 + k));
        search(MAX_WORD);
        load_char(0, 8'h9E);
        load_char(1, 8'h9F);
        load_char(2, 8'h80);
        search(3);

        // Both diagonals and straight down on a two-by-two grid.
        set_grid(CFG_W'(2), CFG_W'(2));
        load_cell(0, 0, "A");
        load_cell(0, 1, "B");
        load_cell(1, 0, "C");
        load_cell(1, 1, "D");
        load_char(0, "A");
        load_char(1, "D");
        search(2);
        load_char(0, "B");
        load_char(1, "C");
        search(2);
        load_char(0, "A");
        search(2);

        // Smallest grid: a two-character word cannot fit, one character can.
        set_grid(CFG_W'(1), CFG_W'(1));
        search(2);
        search(1);

        // Random phases, mostly on small grids, with a stretch free of gaps.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            calm = (phase >= 1 && phase < 3);
            roll = $urandom_range(99);
            if (roll < 8) begin
                rv = 0;
                cv = $urandom_range(63);
            end else if (roll < 16) begin
                rv = $urandom_range(63);
                cv = 0;
            end else if (roll < 24) begin
                rv = $urandom_range(32, 63);
                cv = $urandom_range(1, 2);
            end else if (roll < 32) begin
                rv = $urandom_range(1, 2);
                cv = $urandom_range(32, 63);
            end else begin
                rv = $urandom_range(1, 6);
                cv = $urandom_range(1, 6);
            end
            run_phase(rv, cv, $urandom_range(2, 5), MAX_WORD);
            phase++;
        end
        calm = 1'b0;

        wait_quiet();
        repeat (32) @(posedge i_clk);
        if (ledger.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
